// ===== sv/vtld_pkg.sv =====
// Shared types and constants for the voice tape level decoder.
package vtld_pkg;

    // Parse phases
    localparam logic [2:0] PH_TYPE = 3'd0;
    localparam logic [2:0] PH_LEN0 = 3'd1;
    localparam logic [2:0] PH_LEN1 = 3'd2;
    localparam logic [2:0] PH_LEN2 = 3'd3;
    localparam logic [2:0] PH_TC   = 3'd4;
    localparam logic [2:0] PH_PACK = 3'd5;
    localparam logic [2:0] PH_DATA = 3'd6;
    localparam logic [2:0] PH_STOP = 3'd7;

    // Result status codes
    localparam logic [1:0] ST_SAMPLE  = 2'd0;
    localparam logic [1:0] ST_END     = 2'd1;
    localparam logic [1:0] ST_PACKED  = 2'd2;
    localparam logic [1:0] ST_UNKNOWN = 2'd3;

    // Block type bytes
    localparam logic [7:0] BLK_END  = 8'd0;
    localparam logic [7:0] BLK_DATA = 8'd1;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD_ADJUST = 2'd1;

    localparam logic [7:0] THRESHOLD_RESET     = 8'd30;
    localparam logic [7:0] PERIOD_ADJUST_RESET = 8'd0;
    localparam logic [8:0] MID_LEVEL           = 9'd128;
    localparam logic [9:0] PERIOD_MAX          = 10'd1019;

    typedef struct packed {
        logic       emit;
        logic       level;
        logic [9:0] period_t;
        logic [1:0] status;
    } t_result;

endpackage

// ===== sv/vtld_parser.sv =====
// Block header parser, sample period and hysteresis level for one byte.
module vtld_parser
    import vtld_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  logic [7:0] i_byte,
    input  logic [7:0] i_threshold,
    input  logic [7:0] i_period_adjust,
    output t_result    o_res
);

    logic [2:0]  r_phase, n_phase;
    logic [23:0] r_remaining, n_remaining;
    logic [23:0] r_length, n_length;
    logic [9:0]  r_period, n_period;
    logic        r_level, n_level;

    logic [7:0]  tc_diff;
    logic [10:0] tc_x7;
    logic [10:0] per_sum;
    logic [23:0] rem_dec;
    logic        above, below;

    // base = ((256 - tc) mod 256) * 7 / 2, then signed adjust, clamp at 0
    assign tc_diff = 8'(-i_byte);
    assign tc_x7   = {tc_diff, 3'b000} - {3'b000, tc_diff};
    assign per_sum = {1'b0, tc_x7[10:1]}
                   + {{3{i_period_adjust[7]}}, i_period_adjust};

    // b > 128 + th ; b < 128 - th written as b + th < 128
    assign above   = {1'b0, i_byte} > (MID_LEVEL + {1'b0, i_threshold});
    assign below   = ({1'b0, i_byte} + {1'b0, i_threshold}) < MID_LEVEL;
    assign rem_dec = r_remaining - 24'd1;

    always_comb begin
        n_phase     = r_phase;
        n_remaining = r_remaining;
        n_length    = r_length;
        n_period    = r_period;
        n_level     = r_level;
        o_res       = '{emit: 1'b0, level: 1'b0, period_t: '0, status: ST_SAMPLE};
        unique case (r_phase)
            PH_TYPE: begin
                if (i_byte == BLK_END) begin
                    n_phase      = PH_STOP;
                    n_remaining  = '0;
                    o_res.emit   = 1'b1;
                    o_res.status = ST_END;
                end else if (i_byte != BLK_DATA) begin
                    n_phase      = PH_STOP;
                    n_remaining  = '0;
                    o_res.emit   = 1'b1;
                    o_res.status = ST_UNKNOWN;
                end else begin
                    n_length = '0;
                    n_phase  = PH_LEN0;
                end
            end
            PH_LEN0: begin
                n_length = {16'd0, i_byte};
                n_phase  = PH_LEN1;
            end
            PH_LEN1: begin
                n_length = {8'd0, i_byte, r_length[7:0]};
                n_phase  = PH_LEN2;
            end
            PH_LEN2: begin
                n_length = {i_byte, r_length[15:0]};
                n_phase  = PH_TC;
            end
            PH_TC: begin
                n_period = per_sum[10] ? 10'd0 : per_sum[9:0];
                n_phase  = PH_PACK;
            end
            PH_PACK: begin
                if (i_byte != 8'd0) begin
                    n_phase      = PH_STOP;
                    n_remaining  = '0;
                    o_res.emit   = 1'b1;
                    o_res.status = ST_PACKED;
                end else if (r_length > 24'd2) begin
                    n_remaining = r_length - 24'd2;
                    n_phase     = PH_DATA;
                end else begin
                    n_remaining = '0;
                    n_phase     = PH_TYPE;
                end
            end
            PH_DATA: begin
                if (above) begin
                    n_level = 1'b1;
                end
                if (below) begin
                    n_level = 1'b0;
                end
                n_remaining = rem_dec;
                if (rem_dec == 24'd0) begin
                    n_phase = PH_TYPE;
                end
                o_res.emit     = 1'b1;
                o_res.level    = n_level;
                o_res.period_t = r_period;
                o_res.status   = ST_SAMPLE;
            end
            PH_STOP: begin
                n_phase = PH_STOP;
            end
            default: begin
                n_phase = PH_STOP;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_TYPE;
            r_remaining <= '0;
            r_length    <= '0;
            r_period    <= '0;
            r_level     <= 1'b0;
        end else if (i_step) begin
            r_phase     <= n_phase;
            r_remaining <= n_remaining;
            r_length    <= n_length;
            r_period    <= n_period;
            r_level     <= n_level;
        end
    end

    // Stopped is terminal until reset
    a_stop_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_STOP |=> r_phase == PH_STOP)
        else $error("parser left stopped phase");

    // In the sample phase there is always at least one sample left
    a_data_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_DATA |-> r_remaining != 24'd0)
        else $error("sample phase with no samples left");

    // Outside the sample phase no sample count is left over
    a_idle_no_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase != PH_DATA |-> r_remaining == 24'd0)
        else $error("sample count left outside sample phase");

endmodule

// ===== sv/voc_tape_level_decoder_core.sv =====
// Top level: voice file byte stream to tape level, with output register and config registers.
// Takes one byte per cycle and gives at most one result per byte, in the cycle after the
// transfer; the only storage in the path is the parser state and the output register, so
// a byte can be taken every cycle unless a result is held by downstream stall. Header bytes
// give no result; sample bytes, the end block and errors give one. After an end or error
// all bytes are taken and dropped until reset. Config writes are always ready.
module voc_tape_level_decoder_core
    import vtld_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [7:0]           i_data_byte,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic                 o_level,
    output logic [9:0]           o_period_t,
    output logic [1:0]           o_status,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [7:0]           i_cfg_data
);

    logic [7:0] r_threshold;
    logic [7:0] r_period_adjust;
    logic       r_valid;
    logic       r_level;
    logic [9:0] r_period_t;
    logic [1:0] r_status;
    logic       step;
    t_result    res;

    assign o_cfg_ready = 1'b1;
    assign o_stall     = r_valid && i_stall;
    assign step        = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold     <= THRESHOLD_RESET;
            r_period_adjust <= PERIOD_ADJUST_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_THRESHOLD:     r_threshold     <= i_cfg_data;
                CFG_PERIOD_ADJUST: r_period_adjust <= i_cfg_data;
                default: ;
            endcase
        end
    end

    vtld_parser u_parser (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_step          (step),
        .i_byte          (i_data_byte),
        .i_threshold     (r_threshold),
        .i_period_adjust (r_period_adjust),
        .o_res           (res)
    );

    // Output register: reload whenever it is empty or being drained
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (step) begin
            r_valid <= res.emit;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && res.emit) begin
            r_level    <= res.level;
            r_period_t <= res.period_t;
            r_status   <= res.status;
        end
    end

    assign o_valid    = r_valid;
    assign o_level    = r_level;
    assign o_period_t = r_period_t;
    assign o_status   = r_status;

    a_status_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != ST_SAMPLE |-> !o_level && o_period_t == 10'd0)
        else $error("status result carries level or period");

    a_period_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ST_SAMPLE |-> o_period_t <= PERIOD_MAX)
        else $error("sample period out of range");

    a_no_input_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_valid |-> !o_stall)
        else $error("input stalled with empty output register");

endmodule

// ===== tb/voc_tape_level_decoder_core_tb.sv =====
// Self-checking testbench for the voice tape level decoder core.
module voc_tape_level_decoder_core_tb;
    import vtld_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_B = 2'd3;
    localparam logic [7:0]           PACK_NONE    = 8'd0;
    localparam int                   IDLE_PCT     = 36;
    localparam int                   TARGET_BYTES = 1000;

    typedef struct {
        logic       level;
        logic [9:0] period_t;
        logic [1:0] status;
    } t_tape_result;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_valid = 1'b0;
    logic                 o_stall;
    logic [7:0]           i_data_byte = 8'd0;
    logic                 o_valid;
    logic                 i_stall = 1'b0;
    logic                 o_level;
    logic [9:0]           o_period_t;
    logic [1:0]           o_status;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [7:0]           i_cfg_data = 8'd0;

    voc_tape_level_decoder_core i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_data_byte (i_data_byte),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_level     (o_level),
        .o_period_t  (o_period_t),
        .o_status    (o_status),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Parser mirror
    logic [2:0]        ps_phase;
    logic [23:0]       ps_left;
    logic [23:0]       ps_len;
    logic [9:0]        ps_period;
    logic              ps_level;
    logic [7:0]        ps_thr;
    logic signed [7:0] ps_adjust;

    t_tape_result levels_due[$];
    logic [7:0]   voc_stream[$];
    logic [7:0]   tc_corner[4] = '{8'd0, 8'd1, 8'd128, 8'd255};

    int  idle_pct = IDLE_PCT;
    int  bytes_pushed = 0;
    int  bytes_taken = 0;
    int  cfg_writes = 0;
    int  blocks_sent = 0;
    int  samples_seen = 0;
    int  mismatches = 0;
    int  last_status = -1;
    bit  byte_taken_now = 1'b0;

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("voc_tape_level_decoder_core_tb NOT OK");
        $finish;
    end

    function automatic void close_stream(input logic [1:0] st);
        ps_phase = PH_STOP;
        ps_left  = '0;
        levels_due.push_back('{level: 1'b0, period_t: 10'd0, status: st});
    endfunction

    function automatic void decode_voc_byte(input logic [7:0] b);
        int base;
        int per;
        case (ps_phase)
            PH_TYPE: begin
                if (b == BLK_END) begin
                    close_stream(ST_END);
                end else if (b != BLK_DATA) begin
                    close_stream(ST_UNKNOWN);
                end else begin
                    ps_len   = '0;
                    ps_phase = PH_LEN0;
                end
            end
            PH_LEN0: begin
                ps_len   = {16'd0, b};
                ps_phase = PH_LEN1;
            end
            PH_LEN1: begin
                ps_len[15:8] = b;
                ps_phase     = PH_LEN2;
            end
            PH_LEN2: begin
                ps_len[23:16] = b;
                ps_phase      = PH_TC;
            end
            PH_TC: begin
                // time constant 0 wraps to base 0
                base = ((256 - int'(b)) % 256) * 7 / 2;
                per  = base + int'(ps_adjust);
                if (per < 0) per = 0;
                ps_period = per[9:0];
                ps_phase  = PH_PACK;
            end
            PH_PACK: begin
                if (b != PACK_NONE) begin
                    close_stream(ST_PACKED);
                end else begin
                    ps_left  = (ps_len >= 24'd2) ? ps_len - 24'd2 : 24'd0;
                    ps_phase = (ps_left != 0) ? PH_DATA : PH_TYPE;
                end
            end
            PH_DATA: begin
                if (int'(b) > int'(MID_LEVEL) + int'(ps_thr)) ps_level = 1'b1;
                if (int'(b) < int'(MID_LEVEL) - int'(ps_thr)) ps_level = 1'b0;
                ps_left = ps_left - 24'd1;
                if (ps_left == 0) ps_phase = PH_TYPE;
                levels_due.push_back('{level: ps_level, period_t: ps_period,
                                       status: ST_SAMPLE});
            end
            default: ;
        endcase
    endfunction

    // Checker and predictor; outputs are checked before the new byte is decoded
    always @(posedge i_clk) begin
        t_tape_result want;
        byte_taken_now = 1'b0;
        if (!i_rst_n) begin
            ps_phase  = PH_TYPE;
            ps_left   = '0;
            ps_len    = '0;
            ps_period = '0;
            ps_level  = 1'b0;
            ps_thr    = THRESHOLD_RESET;
            ps_adjust = PERIOD_ADJUST_RESET;
        end else begin
            if (o_valid && !i_stall) begin
                if (levels_due.size() == 0) begin
                    $error("result with nothing pending: level %0d period_t %0d status %0d",
                           o_level, o_period_t, o_status);
                    mismatches++;
                end else begin
                    want = levels_due.pop_front();
                    if (o_level !== want.level) begin
                        $error("level: expected %0d, got %0d", want.level, o_level);
                        mismatches++;
                    end
                    if (o_period_t !== want.period_t) begin
                        $error("period_t: expected %0d, got %0d", want.period_t, o_period_t);
                        mismatches++;
                    end
                    if (o_status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, o_status);
                        mismatches++;
                    end
                    if (want.status == ST_SAMPLE) samples_seen++;
                    else last_status = want.status;
                end
            end
            if (i_valid && !o_stall) begin
                byte_taken_now = 1'b1;
                bytes_taken++;
                decode_voc_byte(i_data_byte);
            end
            if (i_cfg_valid && o_cfg_ready) begin
                cfg_writes++;
                if (i_cfg_index == CFG_THRESHOLD) ps_thr = i_cfg_data;
                else if (i_cfg_index == CFG_PERIOD_ADJUST) ps_adjust = i_cfg_data;
            end
        end
    end

    // Byte source and result stall, both driven on the falling edge
    always @(negedge i_clk) begin
        i_stall <= (int'($urandom_range(99)) < idle_pct);
        if (!i_valid || byte_taken_now) begin
            if (voc_stream.size() != 0 && int'($urandom_range(99)) >= idle_pct) begin
                i_valid     <= 1'b1;
                i_data_byte <= voc_stream.pop_front();
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    task automatic push_byte(input logic [7:0] b);
        voc_stream.push_back(b);
        bytes_pushed++;
    endtask

    task automatic push_header(input logic [23:0] len, input logic [7:0] tc);
        push_byte(BLK_DATA);
        push_byte(len[7:0]);
        push_byte(len[15:8]);
        push_byte(len[23:16]);
        push_byte(tc);
        push_byte(PACK_NONE);
        blocks_sent++;
    endtask

    // Samples cluster on the hysteresis edges, with extremes and mid level mixed in
    function automatic logic [7:0] pick_sample(input logic [7:0] thr);
        int v;
        case ($urandom_range(9))
            0, 1, 2, 3: v = int'($urandom_range(255));
            4, 5:       v = 127 + int'(thr) + int'($urandom_range(2));
            6, 7:       v = 129 - int'(thr) - int'($urandom_range(2));
            8:          v = $urandom_range(1) ? 255 : 0;
            default:    v = int'(MID_LEVEL);
        endcase
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        return v[7:0];
    endfunction

    task automatic push_random_block(input logic [7:0] thr);
        logic [23:0] len;
        logic [7:0]  tc;
        case ($urandom_range(19))
            0:          len = {8'd0, 8'd1, 8'($urandom_range(255))};
            1, 2, 3, 4: len = 24'($urandom_range(255));
            default:    len = 24'($urandom_range(20));
        endcase
        tc = ($urandom_range(3) == 0) ? tc_corner[$urandom_range(3)] : 8'($urandom_range(255));
        push_header(len, tc);
        if (len >= 24'd2) repeat (int'(len) - 2) push_byte(pick_sample(thr));
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
        int target;
        target = cfg_writes + 1;
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = val;
        while (cfg_writes != target) @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic wait_drained();
        while (!(bytes_taken == bytes_pushed && levels_due.size() == 0)) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    initial begin
        int         ph;
        logic [7:0] thr;
        logic [7:0] adj;

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: extreme samples at period 0, short blocks, first level rise
        push_header(24'd5, 8'd0);
        push_byte(8'd255);
        push_byte(8'd0);
        push_byte(MID_LEVEL[7:0]);
        push_header(24'd0, 8'd1);
        push_header(24'd1, 8'd255);
        push_header(24'd3, 8'd1);
        push_byte(8'd159);

        for (ph = 0; bytes_pushed < TARGET_BYTES; ph++) begin
            wait_drained();
            idle_pct = (ph == 1) ? 0 : IDLE_PCT;
            case (ph)
                0:       begin thr = 8'd0;   adj = 8'd127;  end
                1:       begin thr = 8'd255; adj = 8'h80;   end
                2:       begin thr = 8'd128; adj = 8'hFF;   end
                3:       begin thr = 8'd127; adj = 8'd1;    end
                default: begin
                    thr = $urandom_range(1) ? 8'($urandom_range(40)) : 8'($urandom_range(255));
                    adj = 8'($urandom_range(255));
                end
            endcase
            write_reg(CFG_THRESHOLD, thr);
            write_reg(CFG_PERIOD_ADJUST, adj);
            if (ph == 2) begin
                write_reg(CFG_UNUSED_A, 8'($urandom_range(255)));
                write_reg(CFG_UNUSED_B, 8'($urandom_range(255)));
            end
            // longest period, then clamp to zero
            if (ph < 2) begin
                push_header(24'd3, (ph == 0) ? 8'd1 : 8'd255);
                push_byte(pick_sample(thr));
            end
            repeat ((ph == 1) ? 8 : 3) push_random_block(thr);
        end

        // Close the stream one of three ways, then feed bytes that must be dropped
        wait_drained();
        idle_pct = IDLE_PCT;
        case ($urandom_range(2))
            0: push_byte(BLK_END);
            1: begin
                push_byte(BLK_DATA);
                repeat (4) push_byte(8'($urandom_range(255)));
                push_byte(8'($urandom_range(1, 255)));
            end
            default: push_byte(8'($urandom_range(2, 255)));
        endcase
        repeat (16) push_byte(8'($urandom_range(255)));

        wait_drained();
        repeat (8) @(negedge i_clk);
        $display("Sent %0d bytes in %0d data blocks over %0d setting phases, %0d config writes.",
                 bytes_pushed, blocks_sent, ph, cfg_writes);
        $display("Checked %0d samples; stream closed with status %0d.",
                 samples_seen, last_status);
        if (mismatches == 0 && levels_due.size() == 0) begin
            $display("voc_tape_level_decoder_core_tb OK");
        end else begin
            $display("voc_tape_level_decoder_core_tb NOT OK");
        end
        $finish;
    end

endmodule
